/* rtl/core/tdf_pkg.sv */
package tdf_pkg;

    localparam int PRIME_COUNT = 1000;
    localparam int MAX_FACTORS = 64;
    localparam int VALUE_BITS  = 64;

    localparam int PORT_VALUE_W = 64;
    localparam int FACTOR_W     = 13;
    localparam int SIEVE_SIZE   = 1 << FACTOR_W;

    localparam int POS_W = $clog2(PRIME_COUNT + 1);
    localparam int IDX_W = (PRIME_COUNT > 1) ? $clog2(PRIME_COUNT) : 1;
    localparam int NF_W  = $clog2(MAX_FACTORS + 1);

    // result status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_EXHAUSTED = 1'b1;

    // divider: DIV_STEP quotient bits per cycle
    localparam int DIV_STEP   = 8;
    localparam int DIV_CYCLES = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_W      = DIV_CYCLES * DIV_STEP;
    localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    typedef logic [FACTOR_W-1:0] prime_rom_t [PRIME_COUNT];

    // sieve over the 13-bit range, keeps the first PRIME_COUNT primes
    function automatic prime_rom_t build_primes();
        prime_rom_t             tab;
        logic [SIEVE_SIZE-1:0]  comp;
        int                     count;
        tab   = '{default: '0};
        comp  = '0;
        count = 0;
        for (int i = 2; i < SIEVE_SIZE; i++) begin
            if (!comp[i] && count < PRIME_COUNT) begin
                tab[count] = FACTOR_W'(i);
                count = count + 1;
                for (int m = i * i; m < SIEVE_SIZE; m = m + i) begin
                    comp[m] = 1'b1;
                end
            end
        end
        return tab;
    endfunction

    localparam prime_rom_t PRIME_TABLE = build_primes();

endpackage

/* rtl/core/tdf_divider.sv */
module tdf_divider
    import tdf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DIV_W-1:0]    dividend,
    input  logic [FACTOR_W-1:0] divisor,
    output logic                done,
    output logic [DIV_W-1:0]    quotient,
    output logic [FACTOR_W-1:0] remainder
);

    logic                 run_reg,  run_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg,  cnt_next;
    logic [DIV_W-1:0]     quo_reg,  quo_next;
    logic [FACTOR_W-1:0]  rem_reg,  rem_next;
    logic [FACTOR_W-1:0]  dvs_reg,  dvs_next;

    logic [DIV_W-1:0]     q_step;
    logic [FACTOR_W-1:0]  r_step;
    logic [FACTOR_W:0]    t_step;

    // restoring division, DIV_STEP bits per cycle; remainder stays below divisor
    always_comb
    begin
        r_step = rem_reg;
        q_step = quo_reg;
        t_step = '0;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            t_step = {r_step, q_step[DIV_W-1]};
            q_step = {q_step[DIV_W-2:0], 1'b0};
            if (t_step >= {1'b0, dvs_reg})
            begin
                r_step    = FACTOR_W'(t_step - {1'b0, dvs_reg});
                q_step[0] = 1'b1;
            end
            else
            begin
                r_step = t_step[FACTOR_W-1:0];
            end
        end
    end

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            quo_next = q_step;
            rem_next = r_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/core/trial_division_factorizer_unit.sv */
// a value of 0 or 1 is answered in the next cycle; otherwise each table prime tried passes through
// S_FETCH, S_LOAD and S_DIV, and each factor found reruns S_LOAD and S_DIV on the same prime
// throughput: one item at a time, busy stays high until the last result has been issued
// the pace is set by the shared divider, 8 quotient bits per cycle over a 64-bit dividend
// results appear one cycle each on result_valid and cannot be stalled
// reset: rst_n async active low, returns to idle with no result pending
module trial_division_factorizer_unit
    import tdf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [PORT_VALUE_W-1:0] value,
    output logic                    result_valid,
    output logic [FACTOR_W-1:0]     factor,
    output logic                    factor_valid,
    output logic                    status,
    output logic [PORT_VALUE_W-1:0] leftover,
    output logic                    last
);

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,  // waiting for an item
        S_FETCH = 4'b0010,  // prime rom read in flight, or table exhausted check
        S_LOAD  = 4'b0100,  // launch divider with current remainder and prime
        S_DIV   = 4'b1000   // waiting on divider, then decide
    } state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_BITS-1:0]  rem_reg,   rem_next;    // remainder still to factor
    logic [POS_W-1:0]       pos_reg,   pos_next;    // table index under trial
    logic [NF_W-1:0]        nf_reg,    nf_next;     // factors issued for this item
    logic [FACTOR_W-1:0]    prime_reg;              // registered rom output

    // result register
    logic                    res_valid_reg, res_valid_next;
    logic [FACTOR_W-1:0]     factor_reg,    factor_next;
    logic                    fvalid_reg,    fvalid_next;
    logic                    status_reg,    status_next;
    logic [PORT_VALUE_W-1:0] leftover_reg,  leftover_next;
    logic                    last_reg,      last_next;

    logic [VALUE_BITS-1:0]  masked_value;
    logic                   div_start;
    logic                   div_done;
    logic [DIV_W-1:0]       div_quo;
    logic [FACTOR_W-1:0]    div_rem;
    logic [VALUE_BITS-1:0]  quo_trunc;

    // only the low VALUE_BITS of the input take part
    assign masked_value = VALUE_BITS'(value);
    assign quo_trunc    = VALUE_BITS'(div_quo);
    assign div_start    = (state_reg == S_LOAD);

    // prime table rom, read registered; the read output goes unused once the table runs out
    always_ff @(posedge clk)
    begin
        prime_reg <= PRIME_TABLE[pos_reg[IDX_W-1:0]];
    end

    // one shared divider: remainder and quotient of rem_reg by the current prime
    tdf_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (DIV_W'(rem_reg)),
        .divisor   (prime_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        pos_next       = pos_reg;
        nf_next        = nf_reg;
        res_valid_next = 1'b0;
        factor_next    = factor_reg;
        fvalid_next    = fvalid_reg;
        status_next    = status_reg;
        leftover_next  = leftover_reg;
        last_next      = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (masked_value <= VALUE_BITS'(1))
                    begin
                        // zero or one: a single empty result
                        res_valid_next = 1'b1;
                        factor_next    = '0;
                        fvalid_next    = 1'b0;
                        status_next    = STATUS_OK;
                        leftover_next  = '0;
                        last_next      = 1'b1;
                    end
                    else
                    begin
                        rem_next   = masked_value;
                        pos_next   = '0;
                        nf_next    = '0;
                        state_next = S_FETCH;
                    end
                end
            end

            S_FETCH:
            begin
                if (pos_reg == POS_W'(PRIME_COUNT))
                begin
                    // table exhausted with remainder above one
                    res_valid_next = 1'b1;
                    factor_next    = '0;
                    fvalid_next    = 1'b0;
                    status_next    = STATUS_EXHAUSTED;
                    leftover_next  = PORT_VALUE_W'(rem_reg);
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_LOAD;
                end
            end

            S_LOAD:
            begin
                state_next = S_DIV;
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    if (div_rem == '0)
                    begin
                        if (quo_trunc > VALUE_BITS'(1) &&
                            nf_reg >= NF_W'(MAX_FACTORS - 1))
                        begin
                            // factor limit reached, report what is left
                            res_valid_next = 1'b1;
                            factor_next    = '0;
                            fvalid_next    = 1'b0;
                            status_next    = STATUS_EXHAUSTED;
                            leftover_next  = PORT_VALUE_W'(rem_reg);
                            last_next      = 1'b1;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            // prime divides: issue it and, unless the quotient is one, retry the same prime
                            res_valid_next = 1'b1;
                            factor_next    = prime_reg;
                            fvalid_next    = 1'b1;
                            status_next    = STATUS_OK;
                            leftover_next  = '0;
                            last_next      = (quo_trunc == VALUE_BITS'(1));
                            nf_next        = nf_reg + 1'b1;
                            rem_next       = quo_trunc;
                            state_next     = (quo_trunc == VALUE_BITS'(1)) ? S_IDLE : S_LOAD;
                        end
                    end
                    else
                    begin
                        // no luck, move to the next prime
                        pos_next   = pos_reg + 1'b1;
                        state_next = S_FETCH;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rem_reg       <= '0;
            pos_reg       <= '0;
            nf_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rem_reg       <= rem_next;
            pos_reg       <= pos_next;
            nf_reg        <= nf_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        factor_reg   <= factor_next;
        fvalid_reg   <= fvalid_next;
        status_reg   <= status_next;
        leftover_reg <= leftover_next;
        last_reg     <= last_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign factor       = factor_reg;
    assign factor_valid = fvalid_reg;
    assign status       = status_reg;
    assign leftover     = leftover_reg;
    assign last         = last_reg;

endmodule

/* rtl/core/tdf_checker.sv */
module tdf_checker
    import tdf_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic [PORT_VALUE_W-1:0] value,
    input logic                    result_valid,
    input logic [FACTOR_W-1:0]     factor,
    input logic                    factor_valid,
    input logic                    status,
    input logic [PORT_VALUE_W-1:0] leftover,
    input logic                    last
);

    // a non-final result always leaves the block still working on the item
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> busy)
        else $error("non-final item result while idle");

    // the block only goes idle by issuing the final result
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid && last)
        else $error("went idle without a final result");

    // factor results are clean
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && factor_valid |->
            status == STATUS_OK && leftover == '0 && factor != '0)
        else $error("factor result carries error fields");

    // error results end the item and carry no factor
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == STATUS_EXHAUSTED |-> last && !factor_valid && factor == '0)
        else $error("malformed error result");

    // zero or one is answered on the next cycle by a lone empty result
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && value <= PORT_VALUE_W'(1) |=>
            result_valid && last && !factor_valid && status == STATUS_OK)
        else $error("zero or one item not answered at once");

endmodule

bind trial_division_factorizer_unit tdf_checker u_tdf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .value        (value),
    .result_valid (result_valid),
    .factor       (factor),
    .factor_valid (factor_valid),
    .status       (status),
    .leftover     (leftover),
    .last         (last)
);

/* tb/tb_top.sv */
module tb_top;
    import tdf_pkg::*;

    // random items after the directed table
    localparam int ITEM_COUNT = 120;
    // a full walk of the prime table runs with no item moving, the limit must outlast it
    localparam int WATCHDOG_LIMIT = 60000;
    // quiet cycles after the last expected item
    localparam int DRAIN_CYCLES = 30;

    localparam logic [PORT_VALUE_W-1:0] VALUE_MASK =
        {PORT_VALUE_W{1'b1}} >> (PORT_VALUE_W - VALUE_BITS);

    // one result item as it appears on the result ports
    typedef struct {
        logic [FACTOR_W-1:0]     factor;
        logic                    factor_valid;
        logic                    status;
        logic [PORT_VALUE_W-1:0] leftover;
        logic                    last;
    } factor_result_t;

    // one row of the directed table, typed rows carry their single result
    typedef struct {
        logic [PORT_VALUE_W-1:0] value;
        bit                      typed;
        factor_result_t          want;
    } stim_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [PORT_VALUE_W-1:0] value;
    logic                    result_valid;
    logic [FACTOR_W-1:0]     factor;
    logic                    factor_valid;
    logic                    status;
    logic [PORT_VALUE_W-1:0] leftover;
    logic                    last;

    // our own copy of the prime rom
    logic [FACTOR_W-1:0]     primes [PRIME_COUNT];

    // results still owed by the block, oldest first
    factor_result_t          expected_factors [$];
    stim_row_t               directed_rows [$];

    // predictor state, mirrors what the block keeps after each item
    logic [PORT_VALUE_W-1:0] pred_remaining;
    int                      pred_position;
    int                      pred_emitted;

    int                      fail_count  = 0;
    int                      idle_cycles = 0;

    trial_division_factorizer_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .result_valid (result_valid),
        .factor       (factor),
        .factor_valid (factor_valid),
        .status       (status),
        .leftover     (leftover),
        .last         (last)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic factor_result_t make_result(
        input logic [FACTOR_W-1:0]     f,
        input logic                    fv,
        input logic                    st,
        input logic [PORT_VALUE_W-1:0] lo,
        input logic                    la
    );
        factor_result_t r;
        r.factor       = f;
        r.factor_valid = fv;
        r.status       = st;
        r.leftover     = lo;
        r.last         = la;
        return r;
    endfunction

    // first PRIME_COUNT primes by plain trial division
    function automatic void fill_primes();
        int count;
        int cand;
        bit is_prime;
        count = 0;
        cand  = 2;
        while (count < PRIME_COUNT) begin
            is_prime = 1'b1;
            for (int j = 0; j < count && is_prime &&
                 int'(primes[j]) * int'(primes[j]) <= cand; j++) begin
                if (cand % int'(primes[j]) == 0)
                    is_prime = 1'b0;
            end
            if (is_prime) begin
                primes[count] = FACTOR_W'(cand);
                count = count + 1;
            end
            cand = cand + 1;
        end
    endfunction

    // walks the table exactly as the block does and queues every result it owes
    function automatic void predict_factors(input logic [PORT_VALUE_W-1:0] raw);
        logic [PORT_VALUE_W-1:0] rem;
        logic [PORT_VALUE_W-1:0] quo;
        int pos;
        int nf;
        bit done;
        rem  = raw & VALUE_MASK;
        pos  = 0;
        nf   = 0;
        done = 1'b0;
        if (rem <= 1) begin
            // zero or one: a lone empty result
            expected_factors.push_back(make_result('0, 1'b0, STATUS_OK, '0, 1'b1));
        end else begin
            while (!done) begin
                if (pos >= PRIME_COUNT) begin
                    // table ran out with something above one left
                    expected_factors.push_back(
                        make_result('0, 1'b0, STATUS_EXHAUSTED, rem, 1'b1));
                    done = 1'b1;
                end else if (rem % primes[pos] == 0) begin
                    quo = rem / primes[pos];
                    if (quo > 1 && nf >= MAX_FACTORS - 1) begin
                        // factor limit hit, report the remainder before the division
                        expected_factors.push_back(
                            make_result('0, 1'b0, STATUS_EXHAUSTED, rem, 1'b1));
                        done = 1'b1;
                    end else begin
                        expected_factors.push_back(
                            make_result(primes[pos], 1'b1, STATUS_OK, '0, quo == 1));
                        nf   = nf + 1;
                        rem  = quo;
                        done = (quo == 1);
                    end
                end else begin
                    pos = pos + 1;
                end
            end
        end
        pred_remaining = rem;
        pred_position  = pos;
        pred_emitted   = nf;
    endfunction

    function automatic void add_row(input logic [PORT_VALUE_W-1:0] v);
        stim_row_t row;
        row.value = v;
        row.typed = 1'b0;
        row.want  = make_result('0, 1'b0, STATUS_OK, '0, 1'b0);
        directed_rows.push_back(row);
    endfunction

    // rows whose single result is obvious, always the last one
    function automatic void add_typed(
        input logic [PORT_VALUE_W-1:0] v,
        input logic [FACTOR_W-1:0]     f,
        input logic                    fv,
        input logic                    st,
        input logic [PORT_VALUE_W-1:0] lo
    );
        stim_row_t row;
        row.value = v;
        row.typed = 1'b1;
        row.want  = make_result(f, fv, st, lo, 1'b1);
        directed_rows.push_back(row);
    endfunction

    // mostly products of table primes so the walk ends cleanly, plus raw noise
    function automatic logic [PORT_VALUE_W-1:0] random_value();
        logic [PORT_VALUE_W-1:0] v;
        logic [PORT_VALUE_W-1:0] p;
        int kind;
        int top;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 65) begin
            // small primes keep the walk short, a few reach deep into the table
            top = (kind < 45) ? 63 : PRIME_COUNT - 1;
            n   = (kind < 45) ? $urandom_range(1, 24) : $urandom_range(1, 4);
            v   = PORT_VALUE_W'(1);
            repeat (n) begin
                p = PORT_VALUE_W'(primes[$urandom_range(0, top)]);
                if (v <= {PORT_VALUE_W{1'b1}} / p)
                    v = v * p;
            end
        end else if (kind < 75) begin
            // full width, usually ends on the table exhausted path
            v = {$urandom, $urandom};
        end else if (kind < 90) begin
            v = PORT_VALUE_W'($urandom_range(2, 65535));
        end else if (kind < 95) begin
            v = 64'd1 << $urandom_range(0, 63);
        end else begin
            v = PORT_VALUE_W'($urandom_range(0, 1));
        end
        return v;
    endfunction

    // hold start until the block takes the item, then log what it owes
    task automatic send_item(input stim_row_t row);
        @(negedge clk);
        start <= 1'b1;
        value <= row.value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (row.typed)
            expected_factors.push_back(row.want);
        else
            predict_factors(row.value);
    endtask

    // sender gap, value keeps toggling so the block must ignore it
    task automatic pause_sender(input int n);
        repeat (n) begin
            @(negedge clk);
            start <= 1'b0;
            value <= {$urandom, $urandom};
        end
    endtask

    // result checker and watchdog
    always @(posedge clk) begin : check_results
        factor_result_t want;
        if (rst_n) begin
            if ((start && !busy) || result_valid)
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;

            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("trial_division_factorizer_unit regression: fail");
                $finish;
            end else if (result_valid) begin
                if (expected_factors.size() == 0) begin
                    $error("unexpected item: factor %0d, status %0d, leftover %0d",
                           factor, status, leftover);
                    fail_count = fail_count + 1;
                end else begin
                    want = expected_factors.pop_front();
                    if (factor !== want.factor) begin
                        $error("factor mismatch: expected %0d, actual %0d",
                               want.factor, factor);
                        fail_count = fail_count + 1;
                    end
                    if (factor_valid !== want.factor_valid) begin
                        $error("factor_valid mismatch: expected %0d, actual %0d",
                               want.factor_valid, factor_valid);
                        fail_count = fail_count + 1;
                    end
                    if (status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, status);
                        fail_count = fail_count + 1;
                    end
                    if (leftover !== want.leftover) begin
                        $error("leftover mismatch: expected %0d, actual %0d",
                               want.leftover, leftover);
                        fail_count = fail_count + 1;
                    end
                    if (last !== want.last) begin
                        $error("last mismatch: expected %0d, actual %0d",
                               want.last, last);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
    end

    initial begin : stimulus
        stim_row_t row;
        int sent;
        int burst;

        rst_n = 1'b0;
        start = 1'b0;
        value = '0;
        fill_primes();

        // directed table: extremes, special cases, deep walks
        add_typed(64'd0, '0, 1'b0, STATUS_OK, '0);
        add_typed(64'd1, '0, 1'b0, STATUS_OK, '0);
        add_typed(64'd2, 13'd2, 1'b1, STATUS_OK, '0);
        add_typed(64'd7919, 13'd7919, 1'b1, STATUS_OK, '0);
        // first prime past the table
        add_typed(64'd7927, '0, 1'b0, STATUS_EXHAUSTED, 64'd7927);
        add_typed(64'd1000000007, '0, 1'b0, STATUS_EXHAUSTED, 64'd1000000007);
        // large primes, nothing divides them
        add_typed(64'h1FFF_FFFF_FFFF_FFFF, '0, 1'b0, STATUS_EXHAUSTED,
                  64'h1FFF_FFFF_FFFF_FFFF);
        add_typed(64'hFFFF_FFFF_FFFF_FFC5, '0, 1'b0, STATUS_EXHAUSTED,
                  64'hFFFF_FFFF_FFFF_FFC5);
        add_row(64'd4);
        add_row(64'd12);
        add_row(64'h1_0000_0000);
        // most results one value can cause
        add_row(64'h8000_0000_0000_0000);
        // all ones: small factors first, then a remainder beyond the table
        add_row(64'hFFFF_FFFF_FFFF_FFFF);
        add_row(64'hFFFF_FFFF_FFFF_FFFE);
        // top of the table, repeated and paired
        add_row(64'd62710561);
        add_row(64'd62710561 * 64'd62710561);
        add_row(64'd62615533);
        // factor found, then the remainder runs off the table; then two values made only of table primes
        add_row(64'd62773913);
        add_row(64'd614889782588491410);
        add_row(64'd12157665459056928801);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i]);
            if ($urandom_range(0, 2) == 0)
                pause_sender($urandom_range(1, 40));
        end

        // random part in bursts, gaps land at any point of the block's walk
        sent = 0;
        while (sent < ITEM_COUNT) begin
            burst = $urandom_range(1, 8);
            for (int k = 0; k < burst && sent < ITEM_COUNT; k++) begin
                row.value = random_value();
                row.typed = 1'b0;
                row.want  = make_result('0, 1'b0, STATUS_OK, '0, 1'b0);
                send_item(row);
                sent = sent + 1;
            end
            case ($urandom_range(0, 3))
                0: ;
                1: pause_sender($urandom_range(1, 20));
                2: pause_sender($urandom_range(20, 400));
                default: pause_sender($urandom_range(400, 2500));
            endcase
        end
        pause_sender(1);

        while (expected_factors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("trial_division_factorizer_unit regression: pass");
        else
            $display("trial_division_factorizer_unit regression: fail");
        $finish;
    end

endmodule
